// ===== design/sblm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sblm_pkg: shared types and constants of the serial loaded bank mapper
// Register targets, control word layout, bank geometry and the structs that
// pass one decoded beat and one mapping snapshot between the modules.
// ----------------------------------------------------------------------------
package sblm_pkg;

    // Bank geometry: offsets are bank numbers shifted by the bank size
    localparam int PRG_BANK_SHIFT = 14;   // 16K PRG banks
    localparam int CHR_BANK_SHIFT = 12;   // 4K CHR banks
    localparam int PRG_OFS_W      = 18;
    localparam int CHR_OFS_W      = 17;

    localparam int PRG_BANK_W     = 4;
    localparam int CHR_BANK_W     = 5;
    localparam int LOAD_W         = 5;    // serial load length and register width
    localparam int LEFT_W         = 3;
    localparam int COUNT_W        = 5;

    localparam logic [LEFT_W-1:0]  WRITES_PER_LOAD = 3'd5;
    localparam logic [LOAD_W-1:0]  CTRL_RESET      = 5'h0C;  // PRG mode 3, rest zero
    localparam logic [LOAD_W-1:0]  CTRL_PRG_MODE3  = 5'h0C;
    localparam logic [COUNT_W-1:0] PRG_COUNT_RESET = 5'd8;
    localparam logic [CHR_BANK_W-1:0] CHR_HIGH_RESET = 5'd1;

    // Register selected by address bits 14:13
    typedef enum logic [1:0] {
        TGT_CTRL = 2'd0,
        TGT_CHR0 = 2'd1,
        TGT_CHR1 = 2'd2,
        TGT_PRG  = 2'd3
    } t_target;

    // PRG banking modes (control bits 3:2)
    typedef enum logic [1:0] {
        PRG_32K_A   = 2'd0,
        PRG_32K_B   = 2'd1,
        PRG_FIX_LOW = 2'd2,
        PRG_FIX_HIGH = 2'd3
    } t_prg_mode;

    // Mirroring codes as reported
    localparam logic [1:0] MIR_SINGLE     = 2'd0;
    localparam logic [1:0] MIR_VERTICAL   = 2'd1;
    localparam logic [1:0] MIR_HORIZONTAL = 2'd2;

    // One input beat, reduced to the bits that matter
    typedef struct packed {
        logic    soft_reset;
        t_target target;
        logic    port_reset;
        logic    serial_bit;
    } t_map_beat;

    // Mapping state after one beat
    typedef struct packed {
        logic [PRG_BANK_W-1:0] prg_low;
        logic [PRG_BANK_W-1:0] prg_high;
        logic [CHR_BANK_W-1:0] chr_low;
        logic [CHR_BANK_W-1:0] chr_high;
        logic [LOAD_W-1:0]     ctrl;
        logic [LEFT_W-1:0]     left;
    } t_map_view;

endpackage
`default_nettype wire

// ===== design/serial_loaded_bank_mapper.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// serial_loaded_bank_mapper: serially loaded cartridge bank mapper
// Input register, mapper state update, and a result register per CPU write.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (i_s_*): one beat per CPU write into ROM space. tuser holds
//   op (0 write, 1 soft reset of the mapper); tdata holds address and data.
//   Master stream (o_m_*): one beat per accepted input beat, in order, giving
//   the PRG and CHR byte offsets, mirroring, modes and serial writes left as
//   they stand after that write.
//   Config channel (i_cfg_*): writes the PRG bank count; it also reloads the
//   fixed high PRG bank. Write it only while no beat is in flight.
//   Path: a beat is held in the input register, then its result is loaded
//   into the result register. Throughput: one beat per cycle while the
//   receiver takes results; the mapper state update is one pass of logic
//   between the input register and the result register.
//   Reset (i_rst_n low, synchronous): empties both stages, restores the
//   power-on mapping: control 0x0C, PRG banks 0 and count-1, CHR banks 0, 1.
//   Receiver stall: the result register holds; one more beat is taken into
//   the input register, then i_s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module serial_loaded_bank_mapper (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Slave stream
    input  wire logic        i_s_tvalid,
    output      logic        o_s_tready,
    input  wire logic [23:0] i_s_tdata,   // [15:0] address, [23:16] data
    input  wire logic        i_s_tuser,   // [0] op
    // Master stream
    output      logic        o_m_tvalid,
    input  wire logic        i_m_tready,
    // [17:0] prg_low_offset, [35:18] prg_high_offset, [52:36] chr_low_offset,
    // [69:53] chr_high_offset, [71:70] mirroring, [73:72] prg_mode,
    // [74] chr_mode, [77:75] writes_left, [79:78] zero
    output      logic [79:0] o_m_tdata,
    // Configuration write channel: PRG bank count
    input  wire logic        i_cfg_valid,
    output      logic        o_cfg_ready,
    input  wire logic [sblm_pkg::COUNT_W-1:0] i_cfg_data
);
    import sblm_pkg::*;

    logic      r_in_valid;
    t_map_beat r_in_beat;
    logic      r_out_valid;
    t_map_view r_view;

    logic      advance;
    logic      take_in;
    t_map_beat in_beat;
    t_map_view next_view;
    logic [1:0] mir_code;
    logic [1:0] mirroring;

    // Move the held beat into the result register when that register is free
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign take_in    = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    // Keep only address bits 14:13 and data bits 7 and 0
    assign in_beat.soft_reset = i_s_tuser;
    assign in_beat.target     = t_target'(i_s_tdata[14:13]);
    assign in_beat.port_reset = i_s_tdata[23];
    assign in_beat.serial_bit = i_s_tdata[16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in_beat <= in_beat;
        end
    end

    sblm_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_beat      (r_in_beat),
        .i_cfg_wr    (i_cfg_valid),
        .i_cfg_count (i_cfg_data),
        .o_next      (next_view)
    );

    // Result register: hold while stalled, load the post-write snapshot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_view <= next_view;
        end
    end

    // Control codes 0 and 1 both report single screen
    assign mir_code = r_view.ctrl[1:0];
    always_comb begin
        case (mir_code)
            2'd2:    mirroring = MIR_VERTICAL;
            2'd3:    mirroring = MIR_HORIZONTAL;
            default: mirroring = MIR_SINGLE;
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {
        2'b00,
        r_view.left,
        r_view.ctrl[4],
        r_view.ctrl[3:2],
        mirroring,
        {r_view.chr_high, {CHR_BANK_SHIFT{1'b0}}},
        {r_view.chr_low,  {CHR_BANK_SHIFT{1'b0}}},
        {r_view.prg_high, {PRG_BANK_SHIFT{1'b0}}},
        {r_view.prg_low,  {PRG_BANK_SHIFT{1'b0}}}
    };

endmodule
`default_nettype wire

// ===== design/sblm_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sblm_core: serial load port and bank registers
// Shifts in one bit per write, loads the selected register on the fifth write
// and keeps the bank numbers; presents the state after the current beat.
// ----------------------------------------------------------------------------
module sblm_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_step,
    input  wire sblm_pkg::t_map_beat          i_beat,
    input  wire logic                         i_cfg_wr,
    input  wire logic [sblm_pkg::COUNT_W-1:0] i_cfg_count,
    output      sblm_pkg::t_map_view          o_next
);
    import sblm_pkg::*;

    logic [COUNT_W-1:0]    r_count,    n_count;
    logic [LOAD_W-1:0]     r_shift,    n_shift;
    logic [LEFT_W-1:0]     r_left,     n_left;
    logic [LOAD_W-1:0]     r_ctrl,     n_ctrl;
    logic [PRG_BANK_W-1:0] r_prg_low,  n_prg_low;
    logic [PRG_BANK_W-1:0] r_prg_high, n_prg_high;
    logic [CHR_BANK_W-1:0] r_chr_low,  n_chr_low;
    logic [CHR_BANK_W-1:0] r_chr_high, n_chr_high;

    logic [LOAD_W-1:0]     shifted;
    logic [PRG_BANK_W-1:0] prg_val;
    t_prg_mode             prg_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= PRG_COUNT_RESET;
            r_shift    <= '0;
            r_left     <= WRITES_PER_LOAD;
            r_ctrl     <= CTRL_RESET;
            r_prg_low  <= '0;
            r_prg_high <= PRG_COUNT_RESET[PRG_BANK_W-1:0] - 1'b1;
            r_chr_low  <= '0;
            r_chr_high <= CHR_HIGH_RESET;
        end else begin
            r_count    <= n_count;
            r_shift    <= n_shift;
            r_left     <= n_left;
            r_ctrl     <= n_ctrl;
            r_prg_low  <= n_prg_low;
            r_prg_high <= n_prg_high;
            r_chr_low  <= n_chr_low;
            r_chr_high <= n_chr_high;
        end
    end

    assign shifted  = {i_beat.serial_bit, r_shift[LOAD_W-1:1]};
    assign prg_val  = shifted[PRG_BANK_W-1:0];   // bit 4 of a PRG load is dropped
    assign prg_mode = t_prg_mode'(r_ctrl[3:2]);

    always_comb begin
        n_count    = r_count;
        n_shift    = r_shift;
        n_left     = r_left;
        n_ctrl     = r_ctrl;
        n_prg_low  = r_prg_low;
        n_prg_high = r_prg_high;
        n_chr_low  = r_chr_low;
        n_chr_high = r_chr_high;

        if (i_step) begin
            if (i_beat.soft_reset) begin
                n_shift = '0;
                n_left  = WRITES_PER_LOAD;
                n_ctrl  = CTRL_RESET;
            end else if (i_beat.port_reset) begin
                n_shift = '0;
                n_left  = WRITES_PER_LOAD;
                n_ctrl  = r_ctrl | CTRL_PRG_MODE3;
            end else if (r_left inside {[3'd2:3'd5]}) begin
                n_shift = shifted;
                n_left  = r_left - 1'b1;
            end else begin
                n_shift = '0;
                n_left  = WRITES_PER_LOAD;
                case (i_beat.target)
                    TGT_CTRL: begin
                        n_ctrl = shifted;
                    end
                    TGT_CHR0: begin
                        if (r_ctrl[4]) begin
                            n_chr_low = shifted;
                        end else begin
                            n_chr_low  = {shifted[LOAD_W-1:1], 1'b0};
                            n_chr_high = {shifted[LOAD_W-1:1], 1'b1};
                        end
                    end
                    TGT_CHR1: begin
                        if (r_ctrl[4]) begin
                            n_chr_high = shifted;
                        end
                    end
                    TGT_PRG: begin
                        case (prg_mode)
                            PRG_FIX_LOW: begin
                                n_prg_low  = '0;
                                n_prg_high = prg_val;
                            end
                            PRG_FIX_HIGH: begin
                                n_prg_low  = prg_val;
                                n_prg_high = r_count[PRG_BANK_W-1:0] - 1'b1;
                            end
                            default: begin
                                n_prg_low  = {prg_val[PRG_BANK_W-1:1], 1'b0};
                                n_prg_high = {prg_val[PRG_BANK_W-1:1], 1'b1};
                            end
                        endcase
                    end
                    default: begin
                        n_ctrl = r_ctrl;
                    end
                endcase
            end
        end

        // A bank count write also reloads the fixed bank
        if (i_cfg_wr) begin
            n_count    = i_cfg_count;
            n_prg_high = i_cfg_count[PRG_BANK_W-1:0] - 1'b1;
        end
    end

    assign o_next.prg_low  = n_prg_low;
    assign o_next.prg_high = n_prg_high;
    assign o_next.chr_low  = n_chr_low;
    assign o_next.chr_high = n_chr_high;
    assign o_next.ctrl     = n_ctrl;
    assign o_next.left     = n_left;

endmodule
`default_nettype wire
